FILE: rtl/nsd_pkg.sv
package nsd_pkg;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_BODY,
		PH_DIG1,
		PH_DIG2
	} phase_t;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [3:0] HEX_ALPHA_OFS = 4'd9;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_CHAR  = 2'd1;
	localparam logic [1:0] KIND_COMMA = 2'd2;

	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_SUM_OK   = 3'd1;
	localparam logic [2:0] EV_EOL      = 3'd2;
	localparam logic [2:0] EV_IMPLICIT = 3'd3;
	localparam logic [2:0] EV_SUM_BAD  = 3'd4;
	localparam logic [2:0] EV_OVERFLOW = 3'd5;

	localparam logic REG_IGNORE_BAD_SUM = 1'b0;
	localparam logic REG_ALLOW_IMPLICIT = 1'b1;

	typedef struct packed {
		logic [1:0]  char_kind;
		logic [7:0]  payload_byte;
		logic [3:0]  field_number;
		logic [6:0]  char_position;
		logic [2:0]  frame_event;
		logic [4:0]  fields_in_sentence;
		logic [7:0]  computed_sum;
		logic [7:0]  received_sum;
		logic [15:0] sentence_total;
		logic [15:0] error_total;
		logic [31:0] byte_total;
	} result_t;

	// '0'..'9' by low nibble, anything above by (b - 'A' + 10) mod 16
	function automatic logic [3:0] hex_nibble(input logic [7:0] b);
		logic [3:0] n;
		if (b <= CH_NINE) begin
			n = b[3:0];
		end else begin
			n = b[3:0] + HEX_ALPHA_OFS;
		end
		return n;
	endfunction

endpackage

FILE: rtl/nsd_intf.sv
interface nsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface nsd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  char_kind;
	logic [7:0]  payload_byte;
	logic [3:0]  field_number;
	logic [6:0]  char_position;
	logic [2:0]  frame_event;
	logic [4:0]  fields_in_sentence;
	logic [7:0]  computed_sum;
	logic [7:0]  received_sum;
	logic [15:0] sentence_total;
	logic [15:0] error_total;
	logic [31:0] byte_total;

	modport source (
		output valid, output char_kind, output payload_byte, output field_number,
		output char_position, output frame_event, output fields_in_sentence,
		output computed_sum, output received_sum, output sentence_total,
		output error_total, output byte_total, input ready
	);
	modport sink (
		input valid, input char_kind, input payload_byte, input field_number,
		input char_position, input frame_event, input fields_in_sentence,
		input computed_sum, input received_sum, input sentence_total,
		input error_total, input byte_total, output ready
	);
endinterface

FILE: rtl/nmea_sentence_deframer.sv
// channel   dir  handshake     payload
// rx        in   valid/ready   rx_byte
// result    out  valid/ready   tag, frame event, sums, counters
// cfg       in   cfg_we        cfg_index, cfg_wdata
//
// One byte per cycle while rx.ready; accepted bytes yield registered results.
// All parsing state updates in the cycle of the rx transfer.
// Output register plus one skid entry: rx stays ready while one result waits.
// arst_n clears parser state, counters and both result slot valid flags.
module nmea_sentence_deframer #(
	parameter int MAX_FIELDS = 16,
	parameter int MAX_LENGTH = 128
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cfg_we,
	input  logic   cfg_index,
	input  logic   cfg_wdata,
	nsd_byte_if.sink     rx,
	nsd_result_if.source result
);
	import nsd_pkg::*;

	localparam int FP_W = $clog2(MAX_LENGTH);
	localparam int FC_W = $clog2(MAX_FIELDS + 1);

	logic ignore_sum_q;
	logic allow_implicit_q;

	phase_t      phase_q, phase_d;
	logic [7:0]  sum_q, sum_d;
	logic [FP_W-1:0] fill_q, fill_d;
	logic [FC_W-1:0] fcnt_q, fcnt_d;
	logic [7:0]  latch_q, latch_d;
	logic [15:0] sent_q, sent_d;
	logic [15:0] err_q, err_d;
	logic [31:0] bytes_q, bytes_d;

	result_t res;
	result_t out_q, skid_q;
	logic    out_v_q, skid_v_q;

	logic [7:0] b;
	logic       in_fire;
	logic       is_comma, is_star, is_eol, is_implicit;
	logic       len_full, comma_ovf;
	logic       sum_match;

	assign b        = rx.rx_byte;
	assign rx.ready = !skid_v_q;
	assign in_fire  = rx.valid && rx.ready;

	assign is_comma    = (b == CH_COMMA);
	assign is_star     = (b == CH_STAR);
	assign is_eol      = (b == CH_CR) || (b == CH_LF);
	assign is_implicit = allow_implicit_q && (b == CH_DOLLAR);
	assign len_full    = (fill_q >= FP_W'(MAX_LENGTH - 1));
	assign comma_ovf   = (fcnt_q >= FC_W'(MAX_FIELDS)) || len_full;
	assign sum_match   = ((latch_q | {4'b0, hex_nibble(b)}) == sum_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_sum_q     <= 1'b0;
			allow_implicit_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IGNORE_BAD_SUM: ignore_sum_q     <= cfg_wdata;
				REG_ALLOW_IMPLICIT: allow_implicit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_HUNT: begin
				if (b == CH_DOLLAR) phase_d = PH_BODY;
			end
			PH_BODY: begin
				priority if (is_comma) begin
					if (comma_ovf) phase_d = PH_HUNT;
				end else if (is_star) begin
					phase_d = PH_DIG1;
				end else if (is_eol) begin
					phase_d = PH_HUNT;
				end else if (is_implicit) begin
					phase_d = PH_BODY;
				end else begin
					if (len_full) phase_d = PH_HUNT;
				end
			end
			PH_DIG1: phase_d = PH_DIG2;
			PH_DIG2: phase_d = PH_HUNT;
			default: phase_d = PH_HUNT;
		endcase
	end

	always_comb begin
		logic keep_old_sum;
		keep_old_sum = 1'b0;
		sum_d   = sum_q;
		fill_d  = fill_q;
		fcnt_d  = fcnt_q;
		latch_d = latch_q;
		sent_d  = sent_q;
		err_d   = err_q;
		bytes_d = bytes_q + 32'd1;
		res     = '0;

		unique case (phase_q)
			PH_HUNT: begin
				if (b == CH_DOLLAR) begin
					sum_d  = '0;
					fill_d = '0;
					fcnt_d = FC_W'(1);
				end
			end
			PH_BODY: begin
				priority if (is_comma) begin
					if (comma_ovf) begin
						res.frame_event = EV_OVERFLOW;
						err_d = err_q + 16'd1;
					end else begin
						res.char_kind     = KIND_COMMA;
						res.payload_byte  = b;
						res.field_number  = 4'(fcnt_q - FC_W'(1));
						res.char_position = 7'(fill_q);
						fill_d = fill_q + FP_W'(1);
						fcnt_d = fcnt_q + FC_W'(1);
						sum_d  = sum_q ^ b;
					end
				end else if (is_star) begin
					// digits follow
				end else if (is_eol) begin
					res.frame_event        = EV_EOL;
					res.fields_in_sentence = 5'(fcnt_q);
					sent_d = sent_q + 16'd1;
				end else if (is_implicit) begin
					res.frame_event        = EV_IMPLICIT;
					res.fields_in_sentence = 5'(fcnt_q);
					sent_d = sent_q + 16'd1;
					keep_old_sum = 1'b1;
					sum_d  = '0;
					fill_d = '0;
					fcnt_d = FC_W'(1);
				end else begin
					sum_d = sum_q ^ b;
					if (len_full) begin
						res.frame_event = EV_OVERFLOW;
						err_d = err_q + 16'd1;
					end else begin
						res.char_kind     = KIND_CHAR;
						res.payload_byte  = b;
						res.field_number  = 4'(fcnt_q - FC_W'(1));
						res.char_position = 7'(fill_q);
						fill_d = fill_q + FP_W'(1);
					end
				end
			end
			PH_DIG1: begin
				latch_d = {hex_nibble(b), 4'b0};
			end
			PH_DIG2: begin
				latch_d = latch_q | {4'b0, hex_nibble(b)};
				if (ignore_sum_q || sum_match) begin
					res.frame_event        = EV_SUM_OK;
					res.fields_in_sentence = 5'(fcnt_q);
					sent_d = sent_q + 16'd1;
				end else begin
					res.frame_event = EV_SUM_BAD;
					err_d = err_q + 16'd1;
				end
			end
			default: ;
		endcase

		res.computed_sum   = keep_old_sum ? sum_q : sum_d;
		res.received_sum   = latch_d;
		res.sentence_total = sent_d;
		res.error_total    = err_d;
		res.byte_total     = bytes_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			sum_q   <= '0;
			fill_q  <= '0;
			fcnt_q  <= '0;
			latch_q <= '0;
			sent_q  <= '0;
			err_q   <= '0;
			bytes_q <= '0;
		end else if (in_fire) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			fill_q  <= fill_d;
			fcnt_q  <= fcnt_d;
			latch_q <= latch_d;
			sent_q  <= sent_d;
			err_q   <= err_d;
			bytes_q <= bytes_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (in_fire) begin
				if (!out_v_q || result.ready) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (result.ready && skid_v_q) begin
				skid_v_q <= 1'b0;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (!out_v_q || result.ready) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end else if (result.ready && skid_v_q) begin
			out_q <= skid_q;
		end
	end

	assign result.valid              = out_v_q;
	assign result.char_kind          = out_q.char_kind;
	assign result.payload_byte       = out_q.payload_byte;
	assign result.field_number       = out_q.field_number;
	assign result.char_position      = out_q.char_position;
	assign result.frame_event        = out_q.frame_event;
	assign result.fields_in_sentence = out_q.fields_in_sentence;
	assign result.computed_sum       = out_q.computed_sum;
	assign result.received_sum       = out_q.received_sum;
	assign result.sentence_total     = out_q.sentence_total;
	assign result.error_total        = out_q.error_total;
	assign result.byte_total         = out_q.byte_total;

`ifndef ASSERT_OFF
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held without output entry");

	a_digits_end: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && phase_q == PH_DIG2) |=> (phase_q == PH_HUNT))
		else $error("second checksum digit did not end the sentence");

	a_field_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> (fcnt_q != '0 && fcnt_q <= FC_W'(MAX_FIELDS)))
		else $error("field count out of range in sentence body");

	a_byte_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (bytes_q == $past(bytes_q) + 32'd1))
		else $error("byte counter did not advance on transfer");
`endif

endmodule

FILE: dv/nsd_deframer_checker.sv
`timescale 1ns / 100ps

module nsd_deframer_checker #(
	parameter int MAX_FIELDS = 16,
	parameter int MAX_LENGTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_wdata,
	nsd_byte_if         rx,
	nsd_result_if       result,
	output int unsigned mismatches,
	output int unsigned outstanding,
	output int unsigned reports_checked,
	output int unsigned sentences_closed,
	output int unsigned sentences_aborted
);
	import nsd_pkg::*;

	localparam logic [7:0] CH_ZERO    = "0";
	localparam logic [7:0] CH_UP_A    = "A";
	localparam logic [7:0] DIGIT_TEN  = 8'd10;

	logic        ignore_bad;
	logic        allow_implicit;
	phase_t      phase;
	logic [7:0]  run_sum;
	logic [7:0]  fill_pos;
	logic [4:0]  field_cnt;
	logic [7:0]  sum_latch;
	logic [15:0] sentence_cnt;
	logic [15:0] error_cnt;
	logic [31:0] byte_cnt;

	result_t predicted_reports[$];

	function automatic logic [3:0] digit_value(input logic [7:0] b);
		logic [7:0] v;
		if (b <= CH_NINE)
			v = b - CH_ZERO;
		else
			v = b - CH_UP_A + DIGIT_TEN;
		return v[3:0];
	endfunction

	task automatic open_sentence();
		run_sum = '0;
		fill_pos = '0;
		field_cnt = 5'd1;
		phase = PH_BODY;
	endtask

	task automatic deframe_byte(input logic [7:0] b, output result_t r);
		logic [7:0] ended_sum;
		logic       implicit_end;
		r = '0;
		implicit_end = 1'b0;
		ended_sum = run_sum;
		byte_cnt = byte_cnt + 32'd1;
		case (phase)
			PH_HUNT: begin
				if (b == CH_DOLLAR)
					open_sentence();
			end
			PH_BODY: begin
				if (b == CH_COMMA) begin
					if (field_cnt >= MAX_FIELDS || fill_pos + 1 >= MAX_LENGTH) begin
						r.frame_event = EV_OVERFLOW;
						error_cnt = error_cnt + 16'd1;
						phase = PH_HUNT;
					end else begin
						r.char_kind = KIND_COMMA;
						r.payload_byte = b;
						r.field_number = 4'(field_cnt - 5'd1);
						r.char_position = fill_pos[6:0];
						fill_pos = fill_pos + 8'd1;
						field_cnt = field_cnt + 5'd1;
						run_sum = run_sum ^ b;
					end
				end else if (b == CH_STAR) begin
					phase = PH_DIG1;
				end else if (b == CH_CR || b == CH_LF) begin
					r.frame_event = EV_EOL;
					r.fields_in_sentence = field_cnt;
					sentence_cnt = sentence_cnt + 16'd1;
					phase = PH_HUNT;
				end else if (allow_implicit && b == CH_DOLLAR) begin
					r.frame_event = EV_IMPLICIT;
					r.fields_in_sentence = field_cnt;
					sentence_cnt = sentence_cnt + 16'd1;
					implicit_end = 1'b1;
					open_sentence();
				end else begin
					fill_pos = fill_pos + 8'd1;
					run_sum = run_sum ^ b;
					if (fill_pos >= MAX_LENGTH) begin
						r.frame_event = EV_OVERFLOW;
						error_cnt = error_cnt + 16'd1;
						phase = PH_HUNT;
					end else begin
						r.char_kind = KIND_CHAR;
						r.payload_byte = b;
						r.field_number = 4'(field_cnt - 5'd1);
						r.char_position = 7'(fill_pos - 8'd1);
					end
				end
			end
			PH_DIG1: begin
				sum_latch = {digit_value(b), 4'h0};
				phase = PH_DIG2;
			end
			default: begin
				sum_latch[3:0] = digit_value(b);
				if (ignore_bad || sum_latch == run_sum) begin
					r.frame_event = EV_SUM_OK;
					r.fields_in_sentence = field_cnt;
					sentence_cnt = sentence_cnt + 16'd1;
				end else begin
					r.frame_event = EV_SUM_BAD;
					error_cnt = error_cnt + 16'd1;
				end
				phase = PH_HUNT;
			end
		endcase
		r.computed_sum = implicit_end ? ended_sum : run_sum;
		r.received_sum = sum_latch;
		r.sentence_total = sentence_cnt;
		r.error_total = error_cnt;
		r.byte_total = byte_cnt;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		result_t pred;
		if (!arst_n) begin
			ignore_bad = 1'b0;
			allow_implicit = 1'b1;
			phase = PH_HUNT;
			run_sum = '0;
			fill_pos = '0;
			field_cnt = '0;
			sum_latch = '0;
			sentence_cnt = '0;
			error_cnt = '0;
			byte_cnt = '0;
			predicted_reports.delete();
			mismatches = 0;
			reports_checked = 0;
			sentences_closed = 0;
			sentences_aborted = 0;
		end else begin
			if (result.valid && result.ready) begin
				got = '{char_kind: result.char_kind, payload_byte: result.payload_byte,
					field_number: result.field_number, char_position: result.char_position,
					frame_event: result.frame_event,
					fields_in_sentence: result.fields_in_sentence,
					computed_sum: result.computed_sum, received_sum: result.received_sum,
					sentence_total: result.sentence_total, error_total: result.error_total,
					byte_total: result.byte_total};
				if (predicted_reports.size() == 0) begin
					$display("%0t: result transfer with no byte pending, expected none, got %p",
						$time, got);
					mismatches++;
				end else begin
					want = predicted_reports.pop_front();
					check_field("char_kind", 32'(want.char_kind), 32'(got.char_kind));
					check_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
					check_field("field_number", 32'(want.field_number), 32'(got.field_number));
					check_field("char_position", 32'(want.char_position),
						32'(got.char_position));
					check_field("frame_event", 32'(want.frame_event), 32'(got.frame_event));
					check_field("fields_in_sentence", 32'(want.fields_in_sentence),
						32'(got.fields_in_sentence));
					check_field("computed_sum", 32'(want.computed_sum), 32'(got.computed_sum));
					check_field("received_sum", 32'(want.received_sum), 32'(got.received_sum));
					check_field("sentence_total", 32'(want.sentence_total),
						32'(got.sentence_total));
					check_field("error_total", 32'(want.error_total), 32'(got.error_total));
					check_field("byte_total", want.byte_total, got.byte_total);
					reports_checked++;
					if (want.frame_event inside {EV_SUM_OK, EV_EOL, EV_IMPLICIT})
						sentences_closed++;
					else if (want.frame_event inside {EV_SUM_BAD, EV_OVERFLOW})
						sentences_aborted++;
				end
			end
			if (rx.valid && rx.ready) begin
				deframe_byte(rx.rx_byte, pred);
				predicted_reports.push_back(pred);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_IGNORE_BAD_SUM: ignore_bad = cfg_wdata;
					REG_ALLOW_IMPLICIT: allow_implicit = cfg_wdata;
				endcase
			end
		end
		outstanding = predicted_reports.size();
	end

endmodule

FILE: dv/nmea_sentence_deframer_tb.sv
`timescale 1ns / 100ps

module nmea_sentence_deframer_tb;
	import nsd_pkg::*;

	localparam int          WATCHDOG_LIMIT = 1000;
	localparam int          DRAIN_CYCLES   = 4;
	localparam int unsigned PHASE_BYTES    = 300;
	localparam logic [7:0]  CH_ZERO        = "0";
	localparam logic [7:0]  CH_UP_A        = "A";
	localparam logic [7:0]  CH_LO_A        = "a";
	localparam logic [7:0]  DIGIT_TEN      = 8'd10;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic cfg_wdata;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned reports_checked;
	int unsigned sentences_closed;
	int unsigned sentences_aborted;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned bytes_sent;
	int unsigned framed_bytes;
	logic        implicit_on;

	nsd_byte_if   rx_ch();
	nsd_result_if result_ch();

	nmea_sentence_deframer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.rx        (rx_ch),
		.result    (result_ch)
	);

	nsd_deframer_checker frame_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.rx                (rx_ch),
		.result            (result_ch),
		.mismatches        (mismatches),
		.outstanding       (outstanding),
		.reports_checked   (reports_checked),
		.sentences_closed  (sentences_closed),
		.sentences_aborted (sentences_aborted)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(negedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		foreach (s[i])
			send_byte(s[i]);
	endtask

	task automatic send_framed(input logic [7:0] b);
		send_byte(b);
		framed_bytes++;
	endtask

	task automatic drain();
		@(negedge clk);
		rx_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_mode(input logic ignore_bad, input logic implicit,
			input int unsigned idle_pct, input int unsigned stall_pct);
		drain();
		write_reg(REG_IGNORE_BAD_SUM, ignore_bad);
		write_reg(REG_ALLOW_IMPLICIT, implicit);
		implicit_on = implicit;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
	endtask

	function automatic logic [7:0] pick_payload();
		logic [7:0] c;
		do c = 8'($urandom_range(255));
		while (c == CH_COMMA || c == CH_STAR || c == CH_CR || c == CH_LF ||
			(c == CH_DOLLAR && implicit_on));
		return c;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input logic lower);
		if (n < 4'd10)
			return CH_ZERO + 8'(n);
		return (lower ? CH_LO_A : CH_UP_A) + 8'(n) - DIGIT_TEN;
	endfunction

	// mostly short well-formed sentences; a few run past the field or length limit
	task automatic send_random_sentence();
		logic [7:0] sum;
		logic [7:0] c;
		logic       lower;
		int         nfields;
		int         flen;
		int         shape;
		int         ending;
		sum = '0;
		shape = $urandom_range(24);
		nfields = (shape == 0) ? $urandom_range(18, 15) : $urandom_range(6, 1);
		send_framed(CH_DOLLAR);
		for (int f = 0; f < nfields; f++) begin
			if (f != 0) begin
				send_framed(CH_COMMA);
				sum = sum ^ CH_COMMA;
			end
			if (shape == 1)
				flen = $urandom_range(45, 20);
			else if (shape == 0)
				flen = $urandom_range(1, 0);
			else
				flen = $urandom_range(5, 0);
			repeat (flen) begin
				c = pick_payload();
				send_framed(c);
				sum = sum ^ c;
			end
		end
		ending = $urandom_range(9);
		lower = 1'($urandom_range(1));
		if (ending < 5) begin
			send_framed(CH_STAR);
			send_framed(hex_char(sum[7:4], lower));
			send_framed(hex_char(sum[3:0], lower));
		end else if (ending < 7) begin
			send_framed(CH_STAR);
			send_framed(8'($urandom_range(255)));
			send_framed(8'($urandom_range(255)));
		end else if (ending < 9) begin
			send_framed($urandom_range(1) ? CH_CR : CH_LF);
		end
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned goal;
		goal = framed_bytes + count;
		while (framed_bytes < goal) begin
			if ($urandom_range(5) == 0)
				repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
			send_random_sentence();
		end
	endtask

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (rx_ch.valid && rx_ch.ready) ||
					(result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_IGNORE_BAD_SUM;
		cfg_wdata = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		result_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		bytes_sent = 0;
		framed_bytes = 0;
		implicit_on = 1'b1;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		set_mode(1'b0, 1'b1, 0, 0);
		// hunt noise, byte extremes, good sum, lowercase digits, CR/LF ends,
		// implicit end, garbage digits
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("$A");
		send_byte(8'hFF);
		send_byte(8'h00);
		send_text(",*92");
		send_text("$k*6b");
		send_text("$\r$,\n$X$*GZ");

		run_random(PHASE_BYTES);

		set_mode(1'b1, 1'b0, 75, 0);
		// '$' as plain payload, bad sum accepted
		send_text("$$,*00");
		run_random(PHASE_BYTES);

		set_mode(1'b0, 1'b0, 0, 75);
		run_random(PHASE_BYTES);

		set_mode(1'b1, 1'b1, 23, 23);
		run_random(PHASE_BYTES);

		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d bytes (%0d inside sentences); %0d results checked.",
			bytes_sent, framed_bytes, reports_checked);
		$display("Sentences closed: %0d, aborted: %0d, over four register settings.",
			sentences_closed, sentences_aborted);
		if (mismatches == 0 && outstanding == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
